// ===== sv/snt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Smith number test.
// No dependencies.
package snt_pkg;

    localparam int NUMBER_WIDTH_DEFAULT = 32;
    localparam int SUM_W                = 16;  // internal digit-sum width, covers 64-bit numbers
    localparam int DIGIT_SUM_W          = 7;
    localparam int FACTOR_SUM_W         = 8;
    localparam int COMPOSITE_BOUND      = 3;

    // digit-sum operand select
    localparam logic [1:0] SEL_NUMBER = 2'd0;
    localparam logic [1:0] SEL_DIV    = 2'd1;
    localparam logic [1:0] SEL_REST   = 2'd2;

    typedef struct packed {
        logic       load;        // capture number, clear factor sum and count
        logic       dsum_start;
        logic [1:0] dsum_sel;
        logic       save_nsum;   // digit sum of the number is ready
        logic       add_fsum;    // accumulate factor digit sum
        logic       div_start;
        logic       take_quot;   // rest <= rest / d, one more factor
        logic       count_inc;
        logic       next_div;    // d <= d + 1
    } snt_cmd_t;

    typedef struct packed {
        logic dsum_done;
        logic div_done;
        logic stop;        // d > rest / d
        logic divisible;   // rest % d == 0
        logic rest_gt1;
    } snt_status_t;

endpackage

// ===== sv/snt_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module snt_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so W bits hold it
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/snt_dsum.sv =====
`timescale 1ns / 1ps
// Decimal digit sum: shift-add-3 binary to BCD, then one digit added per cycle.
// Depends on snt_pkg.
module snt_dsum
    import snt_pkg::*;
#(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     value,
    output logic             done,
    output logic [SUM_W-1:0] sum
);

    localparam int DIGITS = (W * 3) / 10 + 1;
    localparam int CNT_W  = $clog2(W);

    logic                  busy_reg, busy_next;
    logic                  phase_reg, phase_next;  // 0: convert, 1: add digits
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [W-1:0]          bin_reg, bin_next;
    logic [4*DIGITS-1:0]   bcd_reg, bcd_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [4*DIGITS-1:0]   adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                           : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        sum_next   = sum_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CNT_W'(W - 1);
            bin_next   = value;
            bcd_next   = '0;
            sum_next   = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!phase_reg)
            begin
                bcd_next = {adj[4*DIGITS-2:0], bin_reg[W-1]};
                bin_next = bin_reg << 1;
                if (cnt_reg == '0)
                begin
                    phase_next = 1'b1;
                    cnt_next   = CNT_W'(DIGITS - 1);
                end
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(bcd_reg[3:0]);
                bcd_next = bcd_reg >> 4;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        sum_reg <= sum_next;
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== sv/snt_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: number, remainder and divisor registers, sums, divider and digit-sum unit.
// Depends on snt_pkg, snt_div, snt_dsum.
module snt_dpath
    import snt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  snt_cmd_t                cmd,
    input  logic [NUMBER_WIDTH-1:0] number,
    output snt_status_t             status,
    output logic                    is_smith,
    output logic                    is_composite,
    output logic [DIGIT_SUM_W-1:0]  digit_sum,
    output logic [FACTOR_SUM_W-1:0] factor_digit_sum
);

    localparam int W = NUMBER_WIDTH;

    logic [W-1:0]     n_reg, n_next;
    logic [W-1:0]     rest_reg, rest_next;
    logic [W-1:0]     d_reg, d_next;
    logic [SUM_W-1:0] nsum_reg, nsum_next;
    logic [SUM_W-1:0] fsum_reg, fsum_next;
    logic [1:0]       count_reg, count_next;

    logic [W-1:0]     dsum_operand;
    logic             dsum_done;
    logic [SUM_W-1:0] dsum_value;
    logic             div_done;
    logic [W-1:0]     quotient;
    logic [W-1:0]     remainder;
    logic             composite;

    always_comb
    begin
        unique case (cmd.dsum_sel)
            SEL_NUMBER: dsum_operand = n_reg;
            SEL_DIV:    dsum_operand = d_reg;
            default:    dsum_operand = rest_reg;
        endcase
    end

    snt_dsum #(.W(W)) u_dsum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.dsum_start),
        .value (dsum_operand),
        .done  (dsum_done),
        .sum   (dsum_value)
    );

    snt_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        n_next     = n_reg;
        rest_next  = rest_reg;
        d_next     = d_reg;
        nsum_next  = nsum_reg;
        fsum_next  = fsum_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            n_next     = number;
            rest_next  = number;
            d_next     = W'(2);
            fsum_next  = '0;
            count_next = '0;
        end
        if (cmd.save_nsum)
            nsum_next = dsum_value;
        if (cmd.add_fsum)
            fsum_next = fsum_reg + dsum_value;
        if (cmd.take_quot)
            rest_next = quotient;
        // only "two or more factors" matters, so the count saturates
        if (cmd.count_inc && !count_reg[1])
            count_next = count_reg + 2'd1;
        if (cmd.next_div)
            d_next = d_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rest_reg <= rest_next;
        d_reg    <= d_next;
        nsum_reg <= nsum_next;
        fsum_reg <= fsum_next;
    end

    assign status.dsum_done = dsum_done;
    assign status.div_done  = div_done;
    assign status.stop      = d_reg > quotient;
    assign status.divisible = remainder == '0;
    assign status.rest_gt1  = rest_reg > W'(1);

    assign composite        = (n_reg > W'(COMPOSITE_BOUND)) && count_reg[1];
    assign is_composite     = composite;
    assign is_smith         = composite && (nsum_reg == fsum_reg);
    assign digit_sum        = nsum_reg[DIGIT_SUM_W-1:0];
    assign factor_digit_sum = fsum_reg[FACTOR_SUM_W-1:0];

endmodule

// ===== sv/snt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences digit sums and trial divisions for one number.
// Depends on snt_pkg.
module snt_ctrl
    import snt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        out_free,
    input  snt_status_t status,
    output snt_cmd_t    cmd,
    output logic        idle,
    output logic        emit
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NSUM   = 4'd1;
    localparam logic [3:0] ST_NSUM_W = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_DIV_W  = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_FAC_W  = 4'd6;
    localparam logic [3:0] ST_TAIL   = 4'd7;
    localparam logic [3:0] ST_TAIL_W = 4'd8;
    localparam logic [3:0] ST_FINISH = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_NSUM;
                end
            end
            ST_NSUM:
            begin
                cmd.dsum_start = 1'b1;
                cmd.dsum_sel   = SEL_NUMBER;
                state_next     = ST_NSUM_W;
            end
            ST_NSUM_W:
            begin
                if (status.dsum_done)
                begin
                    cmd.save_nsum = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                if (status.div_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.stop)
                    state_next = status.rest_gt1 ? ST_TAIL : ST_FINISH;
                else if (status.divisible)
                begin
                    // d stays put: retry it on the reduced remainder
                    cmd.take_quot  = 1'b1;
                    cmd.count_inc  = 1'b1;
                    cmd.dsum_start = 1'b1;
                    cmd.dsum_sel   = SEL_DIV;
                    state_next     = ST_FAC_W;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_FAC_W:
            begin
                cmd.dsum_sel = SEL_DIV;
                if (status.dsum_done)
                begin
                    cmd.add_fsum = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_TAIL:
            begin
                cmd.dsum_start = 1'b1;
                cmd.dsum_sel   = SEL_REST;
                state_next     = ST_TAIL_W;
            end
            ST_TAIL_W:
            begin
                cmd.dsum_sel = SEL_REST;
                if (status.dsum_done)
                begin
                    cmd.add_fsum  = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle = state_reg == ST_IDLE;

endmodule

// ===== sv/smith_number_test.sv =====
`timescale 1ns / 1ps
// Smith number test, top level: controller, datapath and output register.
// Each trial divisor runs one division, and up to sqrt(number) divisors are tried; the number,
// each factor found and the remaining factor each take one digit-sum run.
// Throughput: one number at a time; the shared divider loop sets the rate.
// A finished result waits in the output register while the next number is accepted.
// Reset (rst_n, async, active low) clears the controller and the output valid flag.
module smith_number_test
    import snt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    is_smith,
    output logic                    is_composite,
    output logic [DIGIT_SUM_W-1:0]  digit_sum,
    output logic [FACTOR_SUM_W-1:0] factor_digit_sum
);

    snt_cmd_t    cmd;
    snt_status_t status;
    logic        idle;
    logic        emit;
    logic        out_free;

    logic                    smith_w, composite_w;
    logic [DIGIT_SUM_W-1:0]  dsum_w;
    logic [FACTOR_SUM_W-1:0] fsum_w;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    smith_reg, composite_reg;
    logic [DIGIT_SUM_W-1:0]  dsum_reg;
    logic [FACTOR_SUM_W-1:0] fsum_reg;

    assign req_stall = !idle;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    snt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_valid && idle),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle),
        .emit     (emit)
    );

    snt_dpath #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .number           (number),
        .status           (status),
        .is_smith         (smith_w),
        .is_composite     (composite_w),
        .digit_sum        (dsum_w),
        .factor_digit_sum (fsum_w)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            smith_reg     <= smith_w;
            composite_reg <= composite_w;
            dsum_reg      <= dsum_w;
            fsum_reg      <= fsum_w;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign is_smith         = smith_reg;
    assign is_composite     = composite_reg;
    assign digit_sum        = dsum_reg;
    assign factor_digit_sum = fsum_reg;

endmodule
